// ===== design/firc_pkg.sv =====
// ----------------------------------------------------------------------------
// firc_pkg
// Shared types and constants of the circular-buffer FIR filter.
// ----------------------------------------------------------------------------
package firc_pkg;

    localparam int TAPS_DEFAULT = 16;
    localparam int DATA_W       = 16;
    localparam int TAP_W        = 4;
    localparam int ACC_W        = 32;
    localparam int ACC_SHIFT    = 4;
    localparam int OUT_W        = ACC_W - ACC_SHIFT;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 32;

    typedef enum logic {
        OP_COEF   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef struct packed {
        logic clr;
        logic vld;
        logic last;
    } mac_ctl_t;

endpackage

// ===== design/firc_mac.sv =====
// ----------------------------------------------------------------------------
// firc_mac
// Registered multiply followed by a wrapping 32-bit accumulate.
// ----------------------------------------------------------------------------
module firc_mac
    import firc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] sample,
    input  logic signed [DATA_W-1:0] coef,
    output logic        [ACC_W-1:0]  acc,
    output logic                     done
);

    logic signed [2*DATA_W-1:0] prod_full;
    logic signed [ACC_W-1:0]    prod_reg;
    logic                       prod_vld_reg;
    logic                       prod_last_reg;
    logic        [ACC_W-1:0]    acc_reg;
    logic                       done_reg;

    // full-width signed product
    assign prod_full = sample * coef;

    always_ff @(posedge aclk) begin
        prod_reg <= ACC_W'(prod_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            prod_vld_reg  <= ctl.vld;
            prod_last_reg <= ctl.last;
            done_reg      <= prod_vld_reg & prod_last_reg;
        end
    end

    // wraps modulo 2^32
    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== design/fir_filter_circular.sv =====
// ----------------------------------------------------------------------------
// fir_filter_circular
// Direct-form FIR filter with circular sample store and coefficient store,
// one shared multiply-accumulate stepping through the taps.
// ----------------------------------------------------------------------------
//  channel  dir  ports                      content
//  s_       in   tvalid tready tdata tuser  tuser: op, tdata: tap_index, value
//  m_       out  tvalid tready tdata        tdata: filtered
//
//  a coefficient write completes on acceptance; a sample is run through the
//  single mac with one read of each store per tap, and no new item is taken
//  until its result has been loaded into the output register
//  after reset a clearing pass zeroes every entry of both stores
//  a finished result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module fir_filter_circular
    import firc_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // tap_index[3:0], value[19:4], zero
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // filtered[27:0], zero
);

    localparam int PW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(TAPS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [PW-1:0]            clr_cnt_reg;
    logic [PW-1:0]            wpos_reg;
    logic [PW-1:0]            idx_reg;
    logic [PW-1:0]            k_reg;
    logic                     rd_vld_reg;
    logic                     rd_last_reg;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         filt_reg;

    logic signed [DATA_W-1:0] sample_mem [TAPS];
    logic signed [DATA_W-1:0] coef_mem   [TAPS];
    logic signed [DATA_W-1:0] sample_rd_reg;
    logic signed [DATA_W-1:0] coef_rd_reg;

    logic [TAP_W-1:0]         in_tap;
    logic signed [DATA_W-1:0] in_value;
    op_t                      in_op;
    logic                     accept;
    logic                     smp_acc;
    logic                     coef_we;
    logic                     smem_we;
    logic [PW-1:0]            smem_waddr;
    logic [PW-1:0]            cmem_waddr;
    logic signed [DATA_W-1:0] smem_wdata;
    logic signed [DATA_W-1:0] cmem_wdata;
    logic                     out_free;
    logic                     out_load;
    mac_ctl_t                 mac_ctl;
    logic [ACC_W-1:0]         mac_acc;
    logic                     mac_done;

    assign in_tap   = s_tdata[TAP_W-1:0];
    assign in_value = s_tdata[TAP_W +: DATA_W];
    assign in_op    = op_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign smp_acc  = accept & (in_op == OP_SAMPLE);
    assign coef_we  = accept & (in_op == OP_COEF) & (32'(in_tap) < TAPS);

    assign out_free = ~m_tvalid_reg | m_tready;
    assign out_load = (state_reg == ST_OUT) & out_free;

    // memory write ports: zeros during the clearing pass
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            smem_we    = 1'b1;
            smem_waddr = clr_cnt_reg;
            smem_wdata = '0;
            cmem_waddr = clr_cnt_reg;
            cmem_wdata = '0;
        end else begin
            smem_we    = smp_acc;
            smem_waddr = wpos_reg;
            smem_wdata = in_value;
            cmem_waddr = PW'(in_tap);
            cmem_wdata = in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (smem_we) begin
            sample_mem[smem_waddr] <= smem_wdata;
        end
        sample_rd_reg <= sample_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_CLEAR) || coef_we) begin
            coef_mem[cmem_waddr] <= cmem_wdata;
        end
        coef_rd_reg <= coef_mem[k_reg];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_POS) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (smp_acc) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (k_reg == LAST_POS) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            wpos_reg     <= '0;
            idx_reg      <= '0;
            k_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= (state_reg == ST_MAC);
            rd_last_reg <= (state_reg == ST_MAC) & (k_reg == LAST_POS);
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (smp_acc) begin
                // newest sample first, walking backwards
                idx_reg  <= wpos_reg;
                k_reg    <= '0;
                wpos_reg <= (wpos_reg == LAST_POS) ? '0 : wpos_reg + 1'b1;
            end else if (state_reg == ST_MAC) begin
                idx_reg <= (idx_reg == '0) ? LAST_POS : idx_reg - 1'b1;
                k_reg   <= k_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            filt_reg <= mac_acc[ACC_W-1:ACC_SHIFT];
        end
    end

    assign mac_ctl = '{clr: smp_acc, vld: rd_vld_reg, last: rd_last_reg};

    firc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .sample  (sample_rd_reg),
        .coef    (coef_rd_reg),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, filt_reg};

endmodule
